// ===== hw/rtl/rlp_pkg.sv =====
package rlp_pkg;

    localparam int MAX_LENGTH_BYTES = 8;
    localparam int FIELD_COUNT      = 7;

    localparam int BUF_LEN_W   = 32;
    localparam int LEN_W       = 64;
    localparam int FIELD_IDX_W = 3;
    localparam int LEN_CNT_W   = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SINGLE_BYTE_MAX = 8'h7f;
    localparam logic [7:0] SHORT_STR_MAX   = 8'hb7;
    localparam logic [7:0] LONG_STR_MAX    = 8'hbf;
    localparam logic [7:0] SHORT_LIST_MAX  = 8'hf7;

    localparam logic [1:0] STAT_PARSING  = 2'd0;
    localparam logic [1:0] STAT_COMPLETE = 2'd1;
    localparam logic [1:0] STAT_ERROR    = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_CONTENT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 last_byte;
        logic [BUF_LEN_W-1:0] room;
    } t_queue_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ===== hw/rtl/rlp_byte_if.sv =====
interface rlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/rlp_field_if.sv =====
interface rlp_field_if
    import rlp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FIELD_IDX_W-1:0] field_index;
    logic                   content_valid;
    logic [7:0]             content_byte;
    logic                   field_done;
    logic [LEN_W-1:0]       field_length;
    logic [1:0]             parse_status;

    modport source (
        output valid, output field_index, output content_valid, output content_byte,
        output field_done, output field_length, output parse_status, input ready
    );
    modport sink (
        input valid, input field_index, input content_valid, input content_byte,
        input field_done, input field_length, input parse_status, output ready
    );
endinterface

// ===== hw/rtl/rlp_front.sv =====
module rlp_front
    import rlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [BUF_LEN_W-1:0] i_cfg_wr_data,
    rlp_byte_if.sink             i_byte_chan,
    input  t_queue_stat          i_queue_stat,
    output logic                 o_push,
    output t_queue_entry         o_push_entry
);

    logic [BUF_LEN_W-1:0] r_buffer_length;
    logic [BUF_LEN_W-1:0] r_consumed;
    logic [BUF_LEN_W-1:0] n_consumed;
    logic                 accept;

    assign i_byte_chan.ready = !i_queue_stat.full;
    assign accept            = i_byte_chan.valid && !i_queue_stat.full;

    // room left in the buffer before this byte
    always_comb begin
        o_push                 = accept;
        o_push_entry.data_byte = i_byte_chan.data_byte;
        o_push_entry.last_byte = i_byte_chan.last_byte;
        if (r_consumed < r_buffer_length) begin
            o_push_entry.room = r_buffer_length - r_consumed;
        end else begin
            o_push_entry.room = '0;
        end
        if (accept && (r_consumed != '1)) begin
            n_consumed = r_consumed + BUF_LEN_W'(1);
        end else begin
            n_consumed = r_consumed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= '0;
            r_consumed      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_buffer_length <= i_cfg_wr_data;
            end
            r_consumed <= n_consumed;
        end
    end

endmodule

// ===== hw/rtl/rlp_queue.sv =====
module rlp_queue
    import rlp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_entry i_push_entry,
    input  logic         i_pop,
    output t_queue_entry o_head,
    output t_queue_stat  o_stat
);

    t_queue_entry               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [QUEUE_CNT_W-1:0]     r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                if (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
                end
            end
            if (do_pop) begin
                if (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
                end
            end
            case ({do_push, do_pop})
                2'b10: begin
                    r_count <= r_count + QUEUE_CNT_W'(1);
                end
                2'b01: begin
                    r_count <= r_count - QUEUE_CNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/rlp_back.sv =====
module rlp_back
    import rlp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_queue_stat  i_queue_stat,
    input  t_queue_entry i_head,
    output logic         o_pop,
    rlp_field_if.source  o_field_chan
);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [FIELD_IDX_W-1:0] r_cur;
    logic [FIELD_IDX_W-1:0] n_cur;
    logic [LEN_CNT_W-1:0]   r_lbl;
    logic [LEN_CNT_W-1:0]   n_lbl;
    logic [LEN_W-1:0]       r_acc;
    logic [LEN_W-1:0]       n_acc;
    logic [LEN_W-1:0]       r_left;
    logic [LEN_W-1:0]       n_left;
    logic [1:0]             r_status;
    logic [1:0]             n_status;

    logic                   r_out_valid;
    logic [FIELD_IDX_W-1:0] r_out_index;
    logic                   r_out_cvalid;
    logic [7:0]             r_out_cbyte;
    logic                   r_out_done;
    logic [LEN_W-1:0]       r_out_len;
    logic [1:0]             r_out_status;
    logic [FIELD_IDX_W-1:0] n_out_index;
    logic                   n_out_cvalid;
    logic [7:0]             n_out_cbyte;
    logic                   n_out_done;
    logic [LEN_W-1:0]       n_out_len;

    logic [7:0]             b;
    logic [BUF_LEN_W-1:0]   room;
    logic [5:0]             short_len;
    logic [LEN_CNT_W-1:0]   long_cnt;
    logic [LEN_W-1:0]       acc_shift;
    logic [LEN_CNT_W-1:0]   lbl_dec;
    logic [LEN_W-1:0]       left_dec;
    logic                   last_field;

    logic                   d_closed;
    logic                   d_err;
    logic                   d_fin;
    logic [LEN_W-1:0]       d_fin_len;
    logic                   d_content;
    logic                   d_go_length;
    logic                   d_go_content;
    logic                   d_last_err;

    assign o_pop      = !i_queue_stat.empty && (!r_out_valid || o_field_chan.ready);
    assign b          = i_head.data_byte;
    assign room       = i_head.room;
    assign short_len  = b[5:0];
    assign long_cnt   = LEN_CNT_W'(b[2:0]) + LEN_CNT_W'(1);
    assign acc_shift  = {r_acc[LEN_W-9:0], b};
    assign lbl_dec    = (r_lbl != '0) ? r_lbl - LEN_CNT_W'(1) : '0;
    assign left_dec   = (r_left != '0) ? r_left - LEN_W'(1) : '0;
    assign last_field = (r_cur >= FIELD_IDX_W'(FIELD_COUNT));

    // byte decode against the current phase
    always_comb begin
        d_closed     = 1'b0;
        d_err        = 1'b0;
        d_fin        = 1'b0;
        d_fin_len    = '0;
        d_content    = 1'b0;
        d_go_length  = 1'b0;
        d_go_content = 1'b0;
        n_acc        = r_acc;
        n_left       = r_left;
        n_lbl        = r_lbl;
        case (r_phase)
            PH_HEADER: begin
                if (b <= SINGLE_BYTE_MAX) begin
                    if (r_cur == '0 || room == '0) begin
                        d_err = 1'b1;
                    end else begin
                        d_content = 1'b1;
                        d_fin     = 1'b1;
                        d_fin_len = LEN_W'(1);
                    end
                end else if (b <= SHORT_STR_MAX) begin
                    if (r_cur == '0 || room <= BUF_LEN_W'(short_len)) begin
                        d_err = 1'b1;
                    end else if (short_len == '0) begin
                        n_acc = '0;
                        d_fin = 1'b1;
                    end else begin
                        n_acc        = LEN_W'(short_len);
                        n_left       = LEN_W'(short_len);
                        d_go_content = 1'b1;
                    end
                end else if (b <= LONG_STR_MAX) begin
                    if (r_cur == '0 || long_cnt > LEN_CNT_W'(MAX_LENGTH_BYTES)
                            || room <= BUF_LEN_W'(long_cnt)) begin
                        d_err = 1'b1;
                    end else begin
                        n_lbl       = long_cnt;
                        n_acc       = '0;
                        d_go_length = 1'b1;
                    end
                end else if (b <= SHORT_LIST_MAX) begin
                    if (r_cur != '0 || room <= BUF_LEN_W'(short_len)) begin
                        d_err = 1'b1;
                    end else begin
                        n_acc     = LEN_W'(short_len);
                        d_fin     = 1'b1;
                        d_fin_len = LEN_W'(short_len);
                    end
                end else begin
                    if (r_cur != '0 || long_cnt > LEN_CNT_W'(MAX_LENGTH_BYTES)
                            || room <= BUF_LEN_W'(long_cnt)) begin
                        d_err = 1'b1;
                    end else begin
                        n_lbl       = long_cnt;
                        n_acc       = '0;
                        d_go_length = 1'b1;
                    end
                end
            end
            PH_LENGTH: begin
                n_acc = acc_shift;
                n_lbl = lbl_dec;
                if (lbl_dec == '0) begin
                    if (r_cur == '0) begin
                        d_fin     = 1'b1;
                        d_fin_len = acc_shift;
                    end else if (room == '0
                            || acc_shift > LEN_W'(room - BUF_LEN_W'(1))) begin
                        d_err = 1'b1;
                    end else if (acc_shift == '0) begin
                        d_fin = 1'b1;
                    end else begin
                        n_left       = acc_shift;
                        d_go_content = 1'b1;
                    end
                end
            end
            PH_CONTENT: begin
                d_content = 1'b1;
                n_left    = left_dec;
                if (left_dec == '0) begin
                    d_fin     = 1'b1;
                    d_fin_len = r_acc;
                end
            end
            default: begin
                d_closed = 1'b1;
            end
        endcase
        d_last_err = i_head.last_byte && !d_closed && !d_err && !(d_fin && last_field);
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_status = r_status;
        if (!d_closed) begin
            if (d_err) begin
                n_phase  = PH_ERROR;
                n_status = STAT_ERROR;
            end else if (d_fin) begin
                if (last_field) begin
                    n_phase  = PH_DONE;
                    n_status = STAT_COMPLETE;
                end else begin
                    n_phase = PH_HEADER;
                    n_cur   = r_cur + FIELD_IDX_W'(1);
                end
            end else if (d_go_length) begin
                n_phase = PH_LENGTH;
            end else if (d_go_content) begin
                n_phase = PH_CONTENT;
            end
            if (d_last_err) begin
                n_phase  = PH_ERROR;
                n_status = STAT_ERROR;
            end
        end
    end

    // result fields
    always_comb begin
        n_out_index  = d_closed ? '0 : r_cur;
        n_out_cvalid = d_content && !d_err;
        n_out_cbyte  = (d_content && !d_err) ? b : '0;
        n_out_done   = d_fin;
        n_out_len    = d_fin ? d_fin_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cur       <= '0;
            r_lbl       <= '0;
            r_acc       <= '0;
            r_left      <= '0;
            r_status    <= STAT_PARSING;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_cur       <= n_cur;
                r_lbl       <= n_lbl;
                r_acc       <= n_acc;
                r_left      <= n_left;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (o_field_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_index  <= n_out_index;
            r_out_cvalid <= n_out_cvalid;
            r_out_cbyte  <= n_out_cbyte;
            r_out_done   <= n_out_done;
            r_out_len    <= n_out_len;
            r_out_status <= n_status;
        end
    end

    assign o_field_chan.valid         = r_out_valid;
    assign o_field_chan.field_index   = r_out_index;
    assign o_field_chan.content_valid = r_out_cvalid;
    assign o_field_chan.content_byte  = r_out_cbyte;
    assign o_field_chan.field_done    = r_out_done;
    assign o_field_chan.field_length  = r_out_len;
    assign o_field_chan.parse_status  = r_out_status;

endmodule

// ===== hw/rtl/rlp_transaction_field_parser_top.sv =====
// channel         dir  payload
// i_byte_chan     in   data_byte, last_byte
// o_field_chan    out  field_index, content_valid, content_byte, field_done,
//                      field_length, parse_status
// i_cfg_wr_en     in   i_cfg_wr_data = buffer length
//
// one byte per cycle while the queue is not full; each byte yields one registered result
// the per-byte header decode and 64-bit length/counter update in the back end sets the pace
// synchronous active-low reset clears parser state, byte count and buffer length
// a two-entry queue between front and back lets input keep flowing while a result waits

module rlp_transaction_field_parser_top
    import rlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [BUF_LEN_W-1:0] i_cfg_wr_data,
    rlp_byte_if.sink             i_byte_chan,
    rlp_field_if.source          o_field_chan
);

    logic         push;
    t_queue_entry push_entry;
    logic         pop;
    t_queue_entry head;
    t_queue_stat  queue_stat;

    rlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_chan   (i_byte_chan),
        .i_queue_stat  (queue_stat),
        .o_push        (push),
        .o_push_entry  (push_entry)
    );

    rlp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (queue_stat)
    );

    rlp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_stat (queue_stat),
        .i_head       (head),
        .o_pop        (pop),
        .o_field_chan (o_field_chan)
    );

endmodule
